/* rtl/core/bb3_pkg.sv */
// Shared types and constants for the edge-aware 3x3 box blur.
// Used by bb3_avg and box_blur_3x3_edge_aware_top; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bb3_pkg;

    // Pixel and channel widths. Channels are packed red, green, blue from the low bit up.
    localparam int CH_W   = 8;
    localparam int NUM_CH = 3;
    localparam int PIX_W  = CH_W * NUM_CH;

    // A 3x3 box sum of one channel and the count of pixels in it.
    localparam int SUM_W = 12;
    localparam int CNT_W = 4;

    // Rounded average: q = ((2*sum + count) * recip(count)) >> RECIP_SH.
    localparam int NUM_W    = 13;
    localparam int RECIP_W  = 18;
    localparam int RECIP_SH = 18;
    localparam int PROD_W   = NUM_W + RECIP_W;

    // Configuration register file.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int FW_W       = 11;
    localparam int FH_W       = 16;
    localparam int ROW_W      = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

    localparam logic [FW_W-1:0] FW_RESET = 11'd640;
    localparam logic [FH_W-1:0] FH_RESET = 16'd480;

    // Kind of an input transaction.
    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    typedef logic [PIX_W-1:0] pixel_t;

    // One box sum handed from the window logic to the averaging pipeline.
    typedef struct packed {
        logic [SUM_W-1:0] sum_red;
        logic [SUM_W-1:0] sum_green;
        logic [SUM_W-1:0] sum_blue;
        logic [CNT_W-1:0] count;
        logic             last;
    } avg_req_t;

    // ceil(2^RECIP_SH / (2*count)); exact for every numerator the blur can form.
    function automatic logic [RECIP_W-1:0] recip_of(input logic [CNT_W-1:0] count);
        logic [RECIP_W-1:0] r;
        case (count)
            4'd1:    r = 18'd131072;
            4'd2:    r = 18'd65536;
            4'd3:    r = 18'd43691;
            4'd4:    r = 18'd32768;
            4'd5:    r = 18'd26215;
            4'd6:    r = 18'd21846;
            4'd7:    r = 18'd18725;
            4'd8:    r = 18'd16384;
            4'd9:    r = 18'd14564;
            default: r = 18'd131072;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/bb3_avg.sv */
// Averaging pipeline and output register of the 3x3 box blur.
// Turns box sums into rounded channel averages by reciprocal multiplication; uses bb3_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bb3_avg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  bb3_pkg::avg_req_t req,
    output logic              req_ready,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [23:0]       m_axis_tdata,   // out_red, out_green, out_blue
    output logic              m_axis_tlast    // frame_end
);
    import bb3_pkg::*;

    logic [SUM_W-1:0]   sums [NUM_CH];
    logic [NUM_W-1:0]   num  [NUM_CH];
    logic [PROD_W-1:0]  prod [NUM_CH];
    logic [RECIP_W-1:0] recip;

    logic [PROD_W-1:0]  prod_reg [NUM_CH];
    logic               prod_last_reg;
    logic               prod_valid_reg;
    pixel_t             out_data_reg;
    logic               out_last_reg;
    logic               out_valid_reg;

    logic               move_out;
    logic               take_req;

    // Numerator 2*sum + count times the reciprocal of 2*count.
    always_comb
    begin
        sums[0] = req.sum_red;
        sums[1] = req.sum_green;
        sums[2] = req.sum_blue;
        recip   = recip_of(req.count);
        for (int c = 0; c < NUM_CH; c++)
        begin
            num[c]  = NUM_W'({sums[c], 1'b0}) + NUM_W'(req.count);
            prod[c] = PROD_W'(num[c]) * PROD_W'(recip);
        end
    end

    // Handshake between the product stage and the output register.
    assign move_out  = prod_valid_reg && (!out_valid_reg || m_axis_tready);
    assign req_ready = !prod_valid_reg || move_out;
    assign take_req  = req_valid && req_ready;

    // Product stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else if (take_req)
        begin
            prod_valid_reg <= 1'b1;
        end
        else if (move_out)
        begin
            prod_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_req)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                prod_reg[c] <= prod[c];
            end
            prod_last_reg <= req.last;
        end
    end

    // Output register; the quotient is the product shifted down.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (move_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move_out)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                out_data_reg[c*CH_W +: CH_W] <= prod_reg[c][RECIP_SH +: CH_W];
            end
            out_last_reg <= prod_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

/* rtl/core/box_blur_3x3_edge_aware_top.sv */
// Top level of the edge-aware 3x3 box blur: row store, 3x3 window, positions and box sums.
// Depends on bb3_pkg and bb3_avg.
`timescale 1ns / 1ps
`default_nettype none

// Edge-aware 3x3 box blur over an RGB pixel stream in raster order. Each result is the
// per-channel average of the in-frame pixels of the 3x3 box around one pixel, rounded half
// up; pixels outside the frame are left out of both sum and divisor. Results trail the input
// by one row plus one pixel, so after the last pixel of a frame the source sends flush
// transactions (tuser = 1), one per pending result, to drain it; a flush while pixels are
// still expected is dropped, and a pixel sent while draining counts as a flush. tlast marks
// the last result of a frame, after which the next pixel starts a new frame. An input
// transaction first reads the row store entry of its column, then updates the window and
// writes the entry back; a dropped flush is taken without the second step. Results then pass
// a sum register, a multiply stage and the output register. These hold up to three results;
// a transaction with a result waits in its write-back step while all three are full and the
// result side is not ready. Writing frame_width or frame_height restarts the frame. The row
// store has no reset and needs no clearing pass.
module box_blur_3x3_edge_aware_top #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [bb3_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [bb3_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [23:0]                      s_axis_tdata,   // in_red, in_green, in_blue
    input  logic [0:0]                       s_axis_tuser,   // func
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [23:0]                      m_axis_tdata,   // out_red, out_green, out_blue
    output logic                             m_axis_tlast    // frame_end
);
    import bb3_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int EW    = ($clog2(MAX_WIDTH + 1) > FW_W) ? $clog2(MAX_WIDTH + 1) : FW_W;
    localparam logic [EW-1:0] MAX_W_E = EW'(MAX_WIDTH);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    // Configuration and control state.
    logic [FW_W-1:0]  fw_reg;
    logic [FH_W-1:0]  fh_reg;
    state_t           state_reg,   state_next;
    logic [ROW_W-1:0] in_row_reg,  in_row_next;
    logic [COL_W-1:0] in_col_reg,  in_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    pixel_t           win_reg [9];
    pixel_t           win_next [9];
    logic             s1_valid_reg;
    avg_req_t         s1_reg;
    pixel_t           pix_reg;

    // Row store: per column the two rows above the input row, older one in the high half.
    logic [2*PIX_W-1:0] store_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] store_rd_reg;

    logic [EW-1:0]    fw_e;
    logic [EW-1:0]    w_eff;
    logic [FH_W-1:0]  h_eff;
    logic             in_done;
    logic             in_accept;
    logic             drop;
    logic             emit;
    logic             late;
    logic             take;
    logic             go;
    logic             last;
    logic             in_wrap;
    logic             out_wrap;
    logic             avg_ready;
    logic             s1_load;
    logic             store_wr;
    pixel_t           pix;
    pixel_t           win_sh [9];
    pixel_t           src    [9];
    pixel_t           pick   [9];
    logic             mask   [9];
    logic [2:0]       row_ok;
    logic [2:0]       col_ok;
    logic [SUM_W-1:0] sums   [NUM_CH];
    logic [CNT_W-1:0] count;
    avg_req_t         req_next;

    // Effective frame size: a zero counts as one, a width is capped at the store depth.
    assign fw_e    = EW'(fw_reg);
    assign w_eff   = (fw_e == '0) ? EW'(1) : ((fw_e > MAX_W_E) ? MAX_W_E : fw_e);
    assign h_eff   = (fh_reg == '0) ? FH_W'(1) : fh_reg;
    assign in_done = (in_row_reg >= h_eff);

    // Input handshake; an early flush is taken and dropped.
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign drop          = !in_done && (s_axis_tuser[0] == FUNC_FLUSH);

    // Row store access: read on accept, write back while the transaction runs.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            store_rd_reg <= store_mem[in_col_reg];
            pix_reg      <= s_axis_tdata;
        end
        if (store_wr)
        begin
            store_mem[in_col_reg] <= {store_rd_reg[PIX_W-1:0], pix};
        end
    end

    // Window shift and which window feeds the result of this transaction.
    assign take = !in_done;
    assign pix  = take ? pix_reg : '0;
    assign emit = (in_row_reg >= ROW_W'(2)) || ((in_row_reg == ROW_W'(1)) && (in_col_reg != '0));
    assign late = (in_col_reg == '0);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            win_sh[i*3]     = win_reg[i*3 + 1];
            win_sh[i*3 + 1] = win_reg[i*3 + 2];
        end
        win_sh[2] = store_rd_reg[2*PIX_W-1:PIX_W];
        win_sh[5] = store_rd_reg[PIX_W-1:0];
        win_sh[8] = pix;
        for (int k = 0; k < 9; k++)
        begin
            src[k] = late ? win_reg[k] : win_sh[k];
        end
    end

    // In-frame rows and columns of the box around the output position.
    always_comb
    begin
        row_ok[0] = (out_row_reg != '0);
        row_ok[1] = (out_row_reg < h_eff);
        row_ok[2] = ((17'(out_row_reg) + 17'd1) < 17'(h_eff));
        col_ok[0] = (out_col_reg != '0);
        col_ok[1] = (EW'(out_col_reg) < w_eff);
        col_ok[2] = ((EW'(out_col_reg) + EW'(1)) < w_eff);
    end

    // Select and mask the box; a result for the last column of a row is formed before the
    // shift and sees its column at the window's right.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (late)
                begin
                    pick[i*3 + j] = (j < 2) ? src[i*3 + j + 1] : '0;
                    mask[i*3 + j] = row_ok[i] && col_ok[j] && (j < 2);
                end
                else
                begin
                    pick[i*3 + j] = src[i*3 + j];
                    mask[i*3 + j] = row_ok[i] && col_ok[j];
                end
            end
        end
    end

    // Box sums per channel and the in-frame count.
    always_comb
    begin
        count = '0;
        for (int k = 0; k < 9; k++)
        begin
            count = count + CNT_W'(mask[k]);
        end
        for (int c = 0; c < NUM_CH; c++)
        begin
            sums[c] = '0;
            for (int k = 0; k < 9; k++)
            begin
                if (mask[k])
                begin
                    sums[c] = sums[c] + SUM_W'(pick[k][c*CH_W +: CH_W]);
                end
            end
        end
    end

    assign out_wrap = ((EW'(out_col_reg) + EW'(1)) >= w_eff);
    assign last     = ((17'(out_row_reg) + 17'd1) >= 17'(h_eff)) && out_wrap;
    assign in_wrap  = ((EW'(in_col_reg) + EW'(1)) >= w_eff);

    always_comb
    begin
        req_next.sum_red   = sums[0];
        req_next.sum_green = sums[1];
        req_next.sum_blue  = sums[2];
        req_next.count     = count;
        req_next.last      = last;
    end

    // A running transaction waits only when it has a result and the sum register is full.
    assign go       = !emit || !s1_valid_reg || avg_ready;
    assign s1_load  = (state_reg == ST_RUN) && go && emit;
    assign store_wr = (state_reg == ST_RUN) && go && take;

    // Next state of positions, window and sequencer.
    always_comb
    begin
        state_next   = state_reg;
        in_row_next  = in_row_reg;
        in_col_next  = in_col_reg;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        for (int k = 0; k < 9; k++)
        begin
            win_next[k] = win_reg[k];
        end

        if (cfg_we)
        begin
            // A register write restarts the frame.
            in_row_next  = '0;
            in_col_next  = '0;
            out_row_next = '0;
            out_col_next = '0;
            for (int k = 0; k < 9; k++)
            begin
                win_next[k] = '0;
            end
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept && !drop)
                    begin
                        state_next = ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (go)
                    begin
                        state_next = ST_IDLE;
                        for (int k = 0; k < 9; k++)
                        begin
                            win_next[k] = win_sh[k];
                        end
                        if (in_wrap)
                        begin
                            in_col_next = '0;
                            if (in_row_reg != '1)
                            begin
                                in_row_next = in_row_reg + ROW_W'(1);
                            end
                        end
                        else
                        begin
                            in_col_next = in_col_reg + COL_W'(1);
                        end
                        if (emit)
                        begin
                            if (out_wrap)
                            begin
                                out_col_next = '0;
                                out_row_next = out_row_reg + ROW_W'(1);
                            end
                            else
                            begin
                                out_col_next = out_col_reg + COL_W'(1);
                            end
                            if (last)
                            begin
                                // Frame complete: start over.
                                in_row_next  = '0;
                                in_col_next  = '0;
                                out_row_next = '0;
                                out_col_next = '0;
                                for (int k = 0; k < 9; k++)
                                begin
                                    win_next[k] = '0;
                                end
                            end
                        end
                    end
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            fw_reg      <= FW_RESET;
            fh_reg      <= FH_RESET;
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
            for (int k = 0; k < 9; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            in_row_reg  <= in_row_next;
            in_col_reg  <= in_col_next;
            out_row_reg <= out_row_next;
            out_col_reg <= out_col_next;
            for (int k = 0; k < 9; k++)
            begin
                win_reg[k] <= win_next[k];
            end
            if (cfg_we && (cfg_addr == CFG_FRAME_WIDTH))
            begin
                fw_reg <= cfg_data[FW_W-1:0];
            end
            if (cfg_we && (cfg_addr == CFG_FRAME_HEIGHT))
            begin
                fh_reg <= cfg_data[FH_W-1:0];
            end
        end
    end

    // Sum register in front of the averaging pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_load)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (avg_ready)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_reg <= req_next;
        end
    end

    bb3_avg u_avg (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (s1_valid_reg),
        .req           (s1_reg),
        .req_ready     (avg_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire
